### design/psq_pkg.sv
// psq_pkg: shared types, codes and pitch tables for the pitch scale quantiser.
// Used by psq_note_find and pitch_scale_quantiser; no dependencies.
package psq_pkg;

  // Fraction bits of the Q(24-F).F frequency format.
  localparam int FREQ_FRAC_BITS = 8;

  localparam int FREQ_W = 24;
  localparam int TAB_W  = 34;   // table entries: Hz in Q.24, below 2^33
  localparam int OCT_W  = 8;    // signed octave / shift amounts

  localparam logic [FREQ_W-1:0] FMAX = '1;

  // Right shift from a Q.24 table value to Q.F at octave 0.
  localparam logic signed [OCT_W-1:0] QF_BASE_SH = 8'(24 - FREQ_FRAC_BITS);

  // Register indexes
  localparam logic REG_SCALE_MODE = 1'b0;
  localparam logic REG_TRANSPOSE  = 1'b1;

  // scale_mode codes
  localparam logic [3:0] MODE_FREE     = 4'd0;
  localparam logic [3:0] MODE_CHROM    = 4'd1;
  localparam logic [3:0] MODE_MAJOR    = 4'd2;
  localparam logic [3:0] MODE_MINOR    = 4'd3;
  localparam logic [3:0] MODE_PENT     = 4'd4;
  localparam logic [3:0] MODE_MPENT    = 4'd5;
  localparam logic [3:0] MODE_JUST_MAJ = 4'd6;
  localparam logic [3:0] MODE_JUST_MIN = 4'd7;
  localparam logic [3:0] MODE_PYTH_MAJ = 4'd8;
  localparam logic [3:0] MODE_PYTH_MIN = 4'd9;

  typedef struct packed {
    logic [FREQ_W-1:0] freq_in;
    logic              transpose_on;
  } req_t;

  typedef struct packed {
    logic [FREQ_W-1:0] freq_out;
    logic              clipped;
  } rsp_t;

  // Note split into octave (relative to C4) and pitch class.
  typedef struct packed {
    logic signed [OCT_W-1:0] oct;
    logic [3:0]              pc;
  } note_t;

  typedef struct packed {
    logic              clip;
    logic [FREQ_W-1:0] val;
  } qf_t;

  // Equal-tempered C4..B4, Hz in Q.24, rounded to nearest.
  localparam logic [TAB_W-1:0] ET_TAB [12] = '{
    34'((64'd2616255653 * 64'd16777216 + 64'd5000000) / 64'd10000000),
    34'((64'd2771826310 * 64'd16777216 + 64'd5000000) / 64'd10000000),
    34'((64'd2936647679 * 64'd16777216 + 64'd5000000) / 64'd10000000),
    34'((64'd3111269837 * 64'd16777216 + 64'd5000000) / 64'd10000000),
    34'((64'd3296275569 * 64'd16777216 + 64'd5000000) / 64'd10000000),
    34'((64'd3492282314 * 64'd16777216 + 64'd5000000) / 64'd10000000),
    34'((64'd3699944227 * 64'd16777216 + 64'd5000000) / 64'd10000000),
    34'((64'd3919954360 * 64'd16777216 + 64'd5000000) / 64'd10000000),
    34'((64'd4153046976 * 64'd16777216 + 64'd5000000) / 64'd10000000),
    34'((64'd4400000000 * 64'd16777216 + 64'd5000000) / 64'd10000000),
    34'((64'd4661637615 * 64'd16777216 + 64'd5000000) / 64'd10000000),
    34'((64'd4938833013 * 64'd16777216 + 64'd5000000) / 64'd10000000)
  };

  localparam logic [TAB_W-1:0] TQ_C  =
    34'((64'd2616256000 * 64'd16777216 + 64'd5000000) / 64'd10000000);
  localparam logic [TAB_W-1:0] TQ_D  =
    34'((64'd2943288000 * 64'd16777216 + 64'd5000000) / 64'd10000000);
  localparam logic [TAB_W-1:0] TQ_F  =
    34'((64'd3488341330 * 64'd16777216 + 64'd5000000) / 64'd10000000);
  localparam logic [TAB_W-1:0] TQ_G  =
    34'((64'd3924384000 * 64'd16777216 + 64'd5000000) / 64'd10000000);
  localparam logic [TAB_W-1:0] TQ_JE =
    34'((64'd3270320000 * 64'd16777216 + 64'd5000000) / 64'd10000000);
  localparam logic [TAB_W-1:0] TQ_JA =
    34'((64'd4360426700 * 64'd16777216 + 64'd5000000) / 64'd10000000);
  localparam logic [TAB_W-1:0] TQ_JB =
    34'((64'd4905480000 * 64'd16777216 + 64'd5000000) / 64'd10000000);
  localparam logic [TAB_W-1:0] TQ_JEB =
    34'((64'd3139507200 * 64'd16777216 + 64'd5000000) / 64'd10000000);
  localparam logic [TAB_W-1:0] TQ_JAB =
    34'((64'd4186009600 * 64'd16777216 + 64'd5000000) / 64'd10000000);
  localparam logic [TAB_W-1:0] TQ_PE =
    34'((64'd3311199000 * 64'd16777216 + 64'd5000000) / 64'd10000000);
  localparam logic [TAB_W-1:0] TQ_PA =
    34'((64'd4414932000 * 64'd16777216 + 64'd5000000) / 64'd10000000);
  localparam logic [TAB_W-1:0] TQ_PB =
    34'((64'd4966798500 * 64'd16777216 + 64'd5000000) / 64'd10000000);
  localparam logic [TAB_W-1:0] TQ_PEB =
    34'((64'd3100748000 * 64'd16777216 + 64'd5000000) / 64'd10000000);
  localparam logic [TAB_W-1:0] TQ_PAB =
    34'((64'd4134330000 * 64'd16777216 + 64'd5000000) / 64'd10000000);

  // Just major, just minor, Pythagorean major, Pythagorean minor; 7 degrees.
  localparam logic [TAB_W-1:0] TUNED_TAB [4][7] = '{
    '{TQ_C, TQ_D, TQ_JE,  TQ_F, TQ_G, TQ_JA,  TQ_JB},
    '{TQ_C, TQ_D, TQ_JEB, TQ_F, TQ_G, TQ_JAB, TQ_JB},
    '{TQ_C, TQ_D, TQ_PE,  TQ_F, TQ_G, TQ_PA,  TQ_PB},
    '{TQ_C, TQ_D, TQ_PEB, TQ_F, TQ_G, TQ_PAB, TQ_PB}
  };

  localparam logic [2:0] DEG_MAJOR [12] = '{0, 0, 1, 1, 2, 3, 3, 4, 4, 5, 5, 6};
  localparam logic [2:0] DEG_MINOR [12] = '{0, 0, 1, 2, 2, 3, 3, 4, 5, 5, 5, 6};

  // Semitones to step down to reach a scale note.
  localparam logic [1:0] DROP_MAJOR [12] = '{0, 1, 0, 1, 0, 0, 1, 0, 1, 0, 1, 0};
  localparam logic [1:0] DROP_MINOR [12] = '{0, 1, 0, 0, 1, 0, 1, 0, 0, 1, 2, 0};
  localparam logic [1:0] DROP_PENT  [12] = '{0, 1, 0, 1, 2, 0, 1, 0, 1, 0, 1, 2};
  localparam logic [1:0] DROP_MPENT [12] = '{0, 1, 2, 0, 1, 0, 1, 0, 1, 2, 0, 1};

  // Q.24 table value shifted right by sh, rounded half up, saturated.
  // Uses (t + 2^(sh-1)) >> sh == ((t >> (sh-1)) + 1) >> 1.
  function automatic qf_t to_qf(logic [TAB_W-1:0] t, logic signed [OCT_W-1:0] sh);
    qf_t             r;
    logic [5:0]      amt;
    logic [TAB_W-1:0] u;
    logic [TAB_W:0]  w;
    r.clip = 1'b0;
    r.val  = '0;
    if (sh <= 8'sd0) begin
      r.clip = 1'b1;
      r.val  = FMAX;
    end else begin
      amt = (sh > 8'sd34) ? 6'd34 : 6'(sh - 8'sd1);
      u   = t >> amt;
      w   = {1'b0, u} + {{TAB_W{1'b0}}, 1'b1};
      if (w[TAB_W:1] > {{(TAB_W-FREQ_W){1'b0}}, FMAX}) begin
        r.clip = 1'b1;
        r.val  = FMAX;
      end else begin
        r.val = w[FREQ_W:1];
      end
    end
    return r;
  endfunction

endpackage

### design/pitch_scale_quantiser.sv
// pitch_scale_quantiser: top level, snaps a frequency to a musical scale.
// Depends on psq_pkg and psq_note_find.
//
//   port group   dir   handshake             beat contents
//   req_*        in    req_valid/req_stall   req_t: freq_in, transpose_on
//   rsp_*        out   rsp_valid/rsp_stall   rsp_t: freq_out, clipped
//   wr_*/reg_*   in    wr_en                 scale_mode (0), transpose (1)
//
// One beat per cycle sustained while rsp_stall is low. Each beat passes the
// input register, then the result register; all its work sits between them.
// rst is synchronous: both stages empty, scale_mode = chromatic,
// transpose = 0. A stalled result holds the result register; the input
// register still takes one more beat, and req_stall rises only when both
// registers hold a beat and rsp_stall is high.
module pitch_scale_quantiser import psq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  req_t       req_data,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output rsp_t       rsp_data,
  input  logic       wr_en,
  input  logic       reg_index,
  input  logic [6:0] wr_data
);

  // Configuration
  logic [3:0]        scale_mode;
  logic signed [6:0] transpose;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_mode <= MODE_CHROM;
      transpose  <= '0;
    end else if (wr_en) begin
      case (reg_index)
        REG_SCALE_MODE: scale_mode <= wr_data[3:0];
        REG_TRANSPOSE:  transpose  <= $signed(wr_data);
        default: ;
      endcase
    end
  end

  // Pipeline control
  logic req_acc;
  logic out_ld;
  logic s1_valid;
  req_t s1_data;
  rsp_t result;

  assign out_ld    = s1_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = s1_valid && rsp_valid && rsp_stall;
  assign req_acc   = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (req_acc) begin
        s1_valid <= 1'b1;
      end else if (out_ld) begin
        s1_valid <= 1'b0;
      end
      if (out_ld) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_acc) begin
      s1_data <= req_data;
    end
    if (out_ld) begin
      rsp_data <= result;
    end
  end

  // Datapath: note detection
  note_t note;

  psq_note_find u_note (
    .freq (s1_data.freq_in),
    .note (note)
  );

  // Transpose: pc + t + 72 stays in 8..146, so div/mod 12 needs no sign care.
  // floor(s/12) = (s * 171) >> 11 holds across that range.
  logic signed [6:0]       t_eff;
  logic [7:0]              s_sum;
  logic [15:0]             q_prod;
  logic [3:0]              q;
  logic [3:0]              pc_t;
  logic signed [OCT_W-1:0] oct_t;

  assign t_eff  = s1_data.transpose_on ? transpose : 7'sd0;
  assign s_sum  = {4'b0, note.pc} + 8'(t_eff) + 8'd72;
  assign q_prod = {8'b0, s_sum} * 16'd171;
  assign q      = q_prod[14:11];
  assign pc_t   = 4'(s_sum - {1'b0, q, 3'b0} - {2'b0, q, 2'b0});
  assign oct_t  = note.oct + $signed({4'b0, q}) - 8'sd6;

  // Snap down to the scale; drop never crosses below C, so octave holds.
  logic [1:0] drop;
  logic [3:0] pc_s;
  logic [2:0] deg;
  logic [1:0] tsel;
  logic [TAB_W-1:0] tab_val;

  always_comb begin
    case (scale_mode)
      MODE_MAJOR, MODE_JUST_MAJ, MODE_PYTH_MAJ: drop = DROP_MAJOR[pc_t];
      MODE_MINOR, MODE_JUST_MIN, MODE_PYTH_MIN: drop = DROP_MINOR[pc_t];
      MODE_PENT:                                drop = DROP_PENT[pc_t];
      MODE_MPENT:                               drop = DROP_MPENT[pc_t];
      default:                                  drop = 2'd0;
    endcase
  end

  assign pc_s    = pc_t - {2'b0, drop};
  assign tsel    = 2'(scale_mode - MODE_JUST_MAJ);
  assign deg     = tsel[0] ? DEG_MINOR[pc_s] : DEG_MAJOR[pc_s];
  assign tab_val = (scale_mode >= MODE_JUST_MAJ) ? TUNED_TAB[tsel][deg] : ET_TAB[pc_s];

  qf_t snapped;
  assign snapped = to_qf(tab_val, QF_BASE_SH - oct_t);

  // Free mode: whole Hz of the transposed note plus the offset above note n.
  qf_t                     base;
  logic [FREQ_W-1:0]       delta;
  logic signed [OCT_W-1:0] whole_sh;
  logic [TAB_W-1:0]        whole;
  logic                    whole_big;
  logic [FREQ_W:0]         free_sum;
  rsp_t                    free_res;

  assign base      = to_qf(ET_TAB[note.pc], QF_BASE_SH - note.oct);
  assign delta     = (base.val > s1_data.freq_in) ? '0 : s1_data.freq_in - base.val;
  assign whole_sh  = 8'sd24 - oct_t;
  assign whole     = (whole_sh > 8'sd33) ? '0 : ET_TAB[pc_t] >> 6'(whole_sh);
  assign whole_big = whole > TAB_W'(FMAX >> FREQ_FRAC_BITS);
  assign free_sum  = {1'b0, FREQ_W'(whole << FREQ_FRAC_BITS)} + {1'b0, delta};

  always_comb begin
    if (whole_big || free_sum[FREQ_W]) begin
      free_res.freq_out = FMAX;
      free_res.clipped  = 1'b1;
    end else begin
      free_res.freq_out = free_sum[FREQ_W-1:0];
      free_res.clipped  = 1'b0;
    end
  end

  // Result select; zero input and unused modes bypass the datapath.
  always_comb begin
    if (scale_mode > MODE_PYTH_MIN) begin
      result.freq_out = s1_data.freq_in;
      result.clipped  = 1'b0;
    end else if (s1_data.freq_in == '0) begin
      result.freq_out = '0;
      result.clipped  = 1'b0;
    end else if (scale_mode == MODE_FREE) begin
      result = free_res;
    end else begin
      result.freq_out = snapped.val;
      result.clipped  = snapped.clip;
    end
  end

  // Checks
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> (s1_valid && rsp_valid))
    else $error("req_stall with a free pipeline stage");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    out_ld |=> rsp_valid)
    else $error("loaded result not presented");

  a_hold_s1: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !out_ld) |=> (s1_valid && $stable(s1_data)))
    else $error("input stage lost a waiting beat");

  a_clip_sat: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_data.clipped) |-> (rsp_data.freq_out == FMAX))
    else $error("clipped result not saturated");

  a_clip_mode: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_data.clipped) |-> (scale_mode <= MODE_PYTH_MIN))
    else $error("clip raised in pass-through mode");

endmodule

### design/psq_note_find.sv
// psq_note_find: splits a Q.F frequency into octave and pitch class.
// Depends on psq_pkg (ET_TAB, note_t, FREQ_FRAC_BITS).
module psq_note_find import psq_pkg::*; (
  input  logic [FREQ_W-1:0] freq,
  output note_t             note
);

  logic [4:0]        lead;
  logic [FREQ_W-1:0] mant;
  logic [TAB_W-1:0]  mm9;
  logic              below;
  logic [TAB_W-1:0]  mm;
  logic [3:0]        pc;

  // Leading one position; a zero input is handled by the caller.
  always_comb begin
    lead = '0;
    for (int i = 0; i < FREQ_W; i++) begin
      if (freq[i]) begin
        lead = 5'(i);
      end
    end
  end

  // Normalize so the leading one sits at bit 32 of the compare word.
  assign mant  = freq << (5'(FREQ_W - 1) - lead);
  assign mm9   = {1'b0, mant, 9'b0};
  assign below = mm9 < ET_TAB[0];
  assign mm    = below ? {mm9[TAB_W-2:0], 1'b0} : mm9;

  always_comb begin
    pc = '0;
    for (int k = 1; k < 12; k++) begin
      if (mm >= ET_TAB[k]) begin
        pc = 4'(k);
      end
    end
  end

  assign note.oct = $signed({3'b0, lead}) - 8'(8 + FREQ_FRAC_BITS)
                    - $signed({7'b0, below});
  assign note.pc  = pc;

endmodule

### dv/tb.sv
// tb: self-checking testbench for pitch_scale_quantiser.
// Needs psq_pkg (payload types, register and mode codes) and the block's RTL.
// A directed table runs first, then random phases, each under its own register setting.
`timescale 1ns / 100ps

module tb;
  import psq_pkg::*;

  // Modes 10..15 are unused; the block passes the input straight through.
  localparam logic [3:0] MODE_SPARE_LO = 4'd10;
  localparam logic [3:0] MODE_SPARE_HI = 4'd15;

  localparam logic [63:0] FULL            = 64'hFF_FFFF;
  localparam int          ITEMS_PER_PHASE = 41;
  localparam int          NUM_PHASES      = 11;
  localparam int          HOLD_CYCLES     = 60;

  // Tempered C4..B4 and the four tuned scales, in units of 1e-7 Hz.
  localparam longint unsigned ET_DEC [12] = '{
    64'd2616255653, 64'd2771826310, 64'd2936647679, 64'd3111269837,
    64'd3296275569, 64'd3492282314, 64'd3699944227, 64'd3919954360,
    64'd4153046976, 64'd4400000000, 64'd4661637615, 64'd4938833013};
  localparam longint unsigned TUNED_DEC [4][7] = '{
    '{64'd2616256000, 64'd2943288000, 64'd3270320000, 64'd3488341330,
      64'd3924384000, 64'd4360426700, 64'd4905480000},
    '{64'd2616256000, 64'd2943288000, 64'd3139507200, 64'd3488341330,
      64'd3924384000, 64'd4186009600, 64'd4905480000},
    '{64'd2616256000, 64'd2943288000, 64'd3311199000, 64'd3488341330,
      64'd3924384000, 64'd4414932000, 64'd4966798500},
    '{64'd2616256000, 64'd2943288000, 64'd3100748000, 64'd3488341330,
      64'd3924384000, 64'd4134330000, 64'd4966798500}};

  // Scale degree per pitch class, and semitones to drop to the scale note below.
  localparam int DEG_MAJ   [12] = '{0, 0, 1, 1, 2, 3, 3, 4, 4, 5, 5, 6};
  localparam int DEG_MIN   [12] = '{0, 0, 1, 2, 2, 3, 3, 4, 5, 5, 5, 6};
  localparam int DROP_MAJ  [12] = '{0, 1, 0, 1, 0, 0, 1, 0, 1, 0, 1, 0};
  localparam int DROP_MIN  [12] = '{0, 1, 0, 0, 1, 0, 1, 0, 0, 1, 2, 0};
  localparam int DROP_PENT [12] = '{0, 1, 0, 1, 2, 0, 1, 0, 1, 0, 1, 2};
  localparam int DROP_MPNT [12] = '{0, 1, 2, 0, 1, 0, 1, 0, 1, 2, 0, 1};

  typedef struct packed {
    logic        clip;
    logic [63:0] val;
  } scaled_t;

  // One directed beat: register setting, request, and a typed-in result if 'typed'.
  typedef struct packed {
    logic [3:0]        mode;
    logic signed [6:0] shift;
    logic [23:0]       freq;
    logic              ton;
    logic              typed;
    logic [23:0]       out;
    logic              clip;
  } probe_t;

  localparam probe_t PROBES [25] = '{
    // zero in, reset setting
    '{MODE_CHROM,     7'sd0,   24'h000000, 1'b0, 1'b1, 24'h000000, 1'b0},
    // A4 exactly lands on its own table entry
    '{MODE_CHROM,     7'sd0,   24'h01B800, 1'b0, 1'b1, 24'h01B800, 1'b0},
    '{MODE_CHROM,     7'sd0,   24'hFFFFFF, 1'b0, 1'b0, 24'h000000, 1'b0},
    '{MODE_CHROM,     7'sd0,   24'h000001, 1'b1, 1'b0, 24'h000000, 1'b0},
    // top input moved up four octaves saturates
    '{MODE_CHROM,     7'sd48,  24'hFFFFFF, 1'b1, 1'b1, 24'hFFFFFF, 1'b1},
    '{MODE_CHROM,     7'sd48,  24'h000001, 1'b1, 1'b0, 24'h000000, 1'b0},
    // far negative notes, result rounds to nothing
    '{MODE_CHROM,    -7'sd48,  24'h000001, 1'b1, 1'b0, 24'h000000, 1'b0},
    '{MODE_CHROM,    -7'sd48,  24'h000000, 1'b1, 1'b1, 24'h000000, 1'b0},
    '{MODE_FREE,      7'sd0,   24'h01B880, 1'b0, 1'b0, 24'h000000, 1'b0},
    '{MODE_FREE,      7'sd0,   24'h000000, 1'b1, 1'b1, 24'h000000, 1'b0},
    '{MODE_FREE,      7'sd48,  24'hFFFFFF, 1'b1, 1'b0, 24'h000000, 1'b0},
    '{MODE_FREE,     -7'sd48,  24'h123456, 1'b1, 1'b0, 24'h000000, 1'b0},
    '{MODE_MAJOR,     7'sd1,   24'h010000, 1'b1, 1'b0, 24'h000000, 1'b0},
    '{MODE_MINOR,     7'sd0,   24'h02AB00, 1'b0, 1'b0, 24'h000000, 1'b0},
    '{MODE_PENT,      7'sd0,   24'h00C350, 1'b1, 1'b0, 24'h000000, 1'b0},
    '{MODE_MPENT,    -7'sd7,   24'h035000, 1'b1, 1'b0, 24'h000000, 1'b0},
    '{MODE_JUST_MAJ,  7'sd0,   24'h01B800, 1'b0, 1'b0, 24'h000000, 1'b0},
    '{MODE_JUST_MIN,  7'sd0,   24'h00F000, 1'b1, 1'b0, 24'h000000, 1'b0},
    '{MODE_PYTH_MAJ,  7'sd0,   24'h0A0000, 1'b0, 1'b0, 24'h000000, 1'b0},
    // 4 Hz sits many octaves below C4: negative pitch class wrap
    '{MODE_PYTH_MIN,  7'sd5,   24'h000400, 1'b1, 1'b0, 24'h000000, 1'b0},
    // unused modes pass the input through untouched
    '{MODE_SPARE_LO,  7'sd0,   24'h123456, 1'b0, 1'b1, 24'h123456, 1'b0},
    '{MODE_SPARE_HI,  7'sd0,   24'hFFFFFF, 1'b1, 1'b1, 24'hFFFFFF, 1'b0},
    '{MODE_SPARE_HI,  7'sd0,   24'h000000, 1'b0, 1'b1, 24'h000000, 1'b0},
    // transpose register extremes beyond the musical range
    '{MODE_CHROM,    -7'sd64,  24'h01B800, 1'b1, 1'b0, 24'h000000, 1'b0},
    '{MODE_CHROM,     7'sd63,  24'h01B800, 1'b1, 1'b0, 24'h000000, 1'b0}};

  logic       clk = 1'b0;
  logic       rst;
  logic       req_valid;
  logic       req_stall;
  req_t       req_data;
  logic       rsp_valid;
  logic       rsp_stall;
  rsp_t       rsp_data;
  logic       wr_en;
  logic       reg_index;
  logic [6:0] wr_data;

  // Our copy of the block's registers, tracked as they are written.
  logic [3:0]        cfg_mode  = MODE_CHROM;
  logic signed [6:0] cfg_shift = '0;

  logic [63:0] et_hz    [12];
  logic [63:0] tuned_hz [4][7];

  rsp_t snapped_q [$];   // predicted result beats, oldest first
  rsp_t want;
  int   errors   = 0;
  bit   quiet    = 1'b0; // no gaps and no stalls while set
  bit   hold_off = 1'b0; // asks the receiver for one long stall

  always #5 clk = ~clk;

  pitch_scale_quantiser i_dut (
    .clk,
    .rst,
    .req_valid,
    .req_stall,
    .req_data,
    .rsp_valid,
    .rsp_stall,
    .rsp_data,
    .wr_en,
    .reg_index,
    .wr_data
  );

  // ---------------------------------------------------------------- predictor

  // x >= t * 2^oct, exact; x and t both Hz in Q.24
  function automatic bit reaches(logic [63:0] x, logic [63:0] t, int oct);
    logic [127:0] a, b;
    a = x;
    b = t;
    if (oct >= 0) b = b << oct;
    else a = a << (-oct);
    return a >= b;
  endfunction

  // Q.24 Hz times 2^oct into Q.F, round half up, saturate
  function automatic scaled_t hz_to_qf(logic [63:0] t, int oct);
    scaled_t r;
    int      sh;
    sh     = 24 - FREQ_FRAC_BITS - oct;
    r.clip = 1'b0;
    r.val  = '0;
    if (sh <= 0) begin
      r.clip = 1'b1;
      r.val  = FULL;
    end else if (sh < 40) begin
      r.val = (t + (64'd1 << (sh - 1))) >> sh;
      if (r.val > FULL) begin
        r.clip = 1'b1;
        r.val  = FULL;
      end
    end
    return r;
  endfunction

  // pitch class and octave relative to C4 = note 40, true modulo
  function automatic int pclass(int n);
    int r;
    r = (n - 40) % 12;
    if (r < 0) r += 12;
    return r;
  endfunction

  function automatic int octave_of(int n);
    return (n - 40 - pclass(n)) / 12;
  endfunction

  function automatic rsp_t quantise(req_t r);
    rsp_t        o;
    scaled_t     s;
    logic [63:0] v, x, delta, whole, acc;
    int          oct, pc, n, t, sh, sel, deg;
    logic        clip;
    o = '0;
    v = r.freq_in;
    if (cfg_mode > MODE_PYTH_MIN || v == 0) begin
      o.freq_out = (cfg_mode > MODE_PYTH_MIN) ? r.freq_in : '0;
      return o;
    end
    // octave against C4, then pitch class by table compare
    x   = v << (24 - FREQ_FRAC_BITS);
    oct = 0;
    pc  = 11;
    while (oct < 12 && reaches(x, et_hz[0], oct + 1)) oct++;
    while (oct > -48 && !reaches(x, et_hz[0], oct)) oct--;
    while (pc > 0 && !reaches(x, et_hz[pc], oct)) pc--;
    n = 40 + 12 * oct + pc;
    t = r.transpose_on ? int'(cfg_shift) : 0;

    if (cfg_mode == MODE_FREE) begin
      // whole Hz of the moved note plus how far the input sat above its note
      s     = hz_to_qf(et_hz[pc], oct);
      delta = (s.val > v) ? 64'd0 : v - s.val;
      n     = n + t;
      pc    = pclass(n);
      oct   = octave_of(n);
      sh    = 24 - oct;
      clip  = (sh <= 0);
      whole = (sh <= 0 || sh >= 40) ? 64'd0 : et_hz[pc] >> sh;
      if (!clip && whole > (FULL >> FREQ_FRAC_BITS)) clip = 1'b1;
      acc = '0;
      if (!clip) begin
        acc = (whole << FREQ_FRAC_BITS) + delta;
        if (acc > FULL) clip = 1'b1;
      end
      o.clipped  = clip;
      o.freq_out = clip ? FMAX : acc[23:0];
    end else begin
      n  = n + t;
      pc = pclass(n);
      case (cfg_mode)
        MODE_MAJOR, MODE_JUST_MAJ, MODE_PYTH_MAJ: n -= DROP_MAJ[pc];
        MODE_MINOR, MODE_JUST_MIN, MODE_PYTH_MIN: n -= DROP_MIN[pc];
        MODE_PENT:  n -= DROP_PENT[pc];
        MODE_MPENT: n -= DROP_MPNT[pc];
        default: ;
      endcase
      pc  = pclass(n);
      oct = octave_of(n);
      if (cfg_mode >= MODE_JUST_MAJ) begin
        sel = int'(cfg_mode - MODE_JUST_MAJ);
        deg = sel[0] ? DEG_MIN[pc] : DEG_MAJ[pc];
        s   = hz_to_qf(tuned_hz[sel][deg], oct);
      end else begin
        s = hz_to_qf(et_hz[pc], oct);
      end
      o.clipped  = s.clip;
      o.freq_out = s.val[23:0];
    end
    return o;
  endfunction

  // ---------------------------------------------------------------- stimulus

  // 1..3 mostly, sometimes a long 10..30
  function automatic int burst_len();
    if ($urandom_range(99) < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  function automatic int pick_gap();
    if (quiet || $urandom_range(99) < 65) return 0;
    return burst_len();
  endfunction

  // Most often near tempered notes (boundary compares), plus tiny, huge, zero, any.
  function automatic logic [23:0] pick_freq();
    int      k, pc, oct;
    longint  w;
    scaled_t s;
    k = $urandom_range(99);
    if (k < 45) begin
      pc  = $urandom_range(11);
      oct = int'($urandom_range(17)) - 10;
      s   = hz_to_qf(et_hz[pc], oct);
      w   = longint'(s.val) + int'($urandom_range(4)) - 2;
      if (w < 1) w = 1;
      if (w > longint'(FULL)) w = longint'(FULL);
      return w[23:0];
    end
    if (k < 58) return 24'($urandom_range(1, 255));
    if (k < 64) return FMAX - 24'($urandom_range(255));
    if (k < 67) return '0;
    return 24'($urandom());
  endfunction

  // Present one request beat, after an optional gap; returns once it is accepted.
  task automatic offer(input req_t d);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= d;
    do @(posedge clk); while (req_stall);
  endtask

  // Drop valid and wait until every predicted beat has come back.
  task automatic settle();
    @(negedge clk);
    req_valid <= 1'b0;
    while (snapped_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [6:0] val);
    @(negedge clk);
    wr_en     <= 1'b1;
    reg_index <= idx;
    wr_data   <= val;
    @(posedge clk);
    if (idx == REG_SCALE_MODE) cfg_mode = val[3:0];
    else cfg_shift = val;
    @(negedge clk);
    wr_en <= 1'b0;
  endtask

  // ---------------------------------------------------------------- receiver

  // Random stall runs; one long hold-off on request so the two stages fill
  // and req_stall has to rise while beats keep being offered.
  initial begin : rsp_side
    int run;
    rsp_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        rsp_stall <= 1'b0;
        hold_off = 1'b0;
      end else if (!quiet && $urandom_range(99) < 20) begin
        run = burst_len();
        rsp_stall <= 1'b1;
        repeat (run) @(negedge clk);
        rsp_stall <= 1'b0;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  // Every accepted result beat is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (snapped_q.size() == 0) begin
        $error("result beat with nothing pending: freq_out %h clipped %b",
               rsp_data.freq_out, rsp_data.clipped);
        errors++;
      end else begin
        want = snapped_q.pop_front();
        if (rsp_data.freq_out !== want.freq_out) begin
          $error("freq_out: expected %h, got %h", want.freq_out, rsp_data.freq_out);
          errors++;
        end
        if (rsp_data.clipped !== want.clipped) begin
          $error("clipped: expected %b, got %b", want.clipped, rsp_data.clipped);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- main flow

  initial begin : main
    req_t d;
    rsp_t lit;
    int   mode, shift;
    rst       = 1'b1;
    req_valid = 1'b0;
    req_data  = '0;
    wr_en     = 1'b0;
    reg_index = REG_SCALE_MODE;
    wr_data   = '0;
    for (int i = 0; i < 12; i++)
      et_hz[i] = (ET_DEC[i] * 64'd16777216 + 64'd5000000) / 64'd10000000;
    for (int s = 0; s < 4; s++)
      for (int g = 0; g < 7; g++)
        tuned_hz[s][g] = (TUNED_DEC[s][g] * 64'd16777216 + 64'd5000000) / 64'd10000000;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table: registers change only between beats, with the block drained.
    foreach (PROBES[i]) begin
      if (PROBES[i].mode != cfg_mode || PROBES[i].shift != cfg_shift) begin
        settle();
        write_reg(REG_SCALE_MODE, {3'b000, PROBES[i].mode});
        write_reg(REG_TRANSPOSE, PROBES[i].shift);
      end
      d.freq_in      = PROBES[i].freq;
      d.transpose_on = PROBES[i].ton;
      offer(d);
      if (PROBES[i].typed) begin
        lit.freq_out = PROBES[i].out;
        lit.clipped  = PROBES[i].clip;
        snapped_q.push_back(lit);
      end else begin
        snapped_q.push_back(quantise(d));
      end
    end

    // Random phases: every mode once, then an unused one; transpose extremes
    // on a few phases. Upper bits of the mode write are junk the block ignores.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      mode = (ph < 10) ? ph : $urandom_range(MODE_SPARE_LO, MODE_SPARE_HI);
      case (ph)
        0:       shift = 48;
        4:       shift = 63;
        7:       shift = -64;
        9:       shift = -48;
        default: shift = int'($urandom_range(96)) - 48;
      endcase
      write_reg(REG_SCALE_MODE, {3'($urandom_range(7)), 4'(mode)});
      write_reg(REG_TRANSPOSE, 7'(shift));
      quiet    = (ph % 4 == 3);
      hold_off = (ph == 2);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        d.freq_in      = pick_freq();
        d.transpose_on = 1'($urandom_range(1));
        offer(d);
        snapped_q.push_back(quantise(d));
      end
    end

    settle();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Generous ceiling on run time, far above the slowest legal run.
  initial begin : watchdog
    #3_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
